>>> rtl/ftpd_pkg.sv
// ----------------------------------------------------------------------------
// ftpd_pkg
// Shared widths, constants and the CORDIC arctangent table for the frame
// transform point decimator.
// ----------------------------------------------------------------------------
package ftpd_pkg;

  localparam int CordicSteps = 16;
  localparam int MaxSteps    = 24;
  localparam int StepW       = 5;
  localparam int CordicLast  = ((CordicSteps > MaxSteps) ? MaxSteps : CordicSteps) - 1;

  localparam int PosW  = 32;
  localparam int HdgW  = 16;
  localparam int ThrW  = 31;
  localparam int AngW  = 33;
  localparam int CorW  = 34;
  localparam int MulW  = 34;
  localparam int ProdW = 68;
  localparam int AccW  = 68;
  localparam int SqW   = 64;
  localparam int FracShift = 30;

  localparam logic [CorW-1:0] CordicGain = 34'd652032874;
  localparam logic [AccW-1:0] RoundHalf  = 68'd536870912;
  localparam logic [ThrW-1:0] ThrReset   = 31'd3277;

  function automatic logic [31:0] atan_lut(input logic [StepW-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051D;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F29;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2F9;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A2F;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028B;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/ftpd_cordic.sv
// ----------------------------------------------------------------------------
// ftpd_cordic
// Rotation-mode CORDIC, one micro-rotation per cycle, giving cos and sin of
// a 16-bit binary angle in Q2.30.
// ----------------------------------------------------------------------------
module ftpd_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [ftpd_pkg::HdgW-1:0]           heading_i,
  output logic                                done_o,
  output logic signed [ftpd_pkg::CorW-1:0]    cos_o,
  output logic signed [ftpd_pkg::CorW-1:0]    sin_o
);

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_DONE} cstate_e;

  cstate_e                              state_q;
  logic signed [ftpd_pkg::CorW-1:0]     x_q, y_q;
  logic signed [ftpd_pkg::AngW-1:0]     z_q;
  logic [ftpd_pkg::StepW-1:0]           step_q;
  logic                                 flip_q;

  logic signed [ftpd_pkg::CorW-1:0]     xs, ys;
  logic signed [ftpd_pkg::AngW-1:0]     atan_s;
  logic [31:0]                          ang;
  logic                                 flip;

  assign ang    = {heading_i, 16'h0000};
  assign flip   = ang[31] ^ ang[30];
  assign xs     = x_q >>> step_q;
  assign ys     = y_q >>> step_q;
  assign atan_s = $signed({1'b0, ftpd_pkg::atan_lut(step_q)});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      step_q  <= '0;
      flip_q  <= 1'b0;
    end else begin
      case (state_q)
        C_IDLE: begin
          if (start_i) begin
            x_q     <= ftpd_pkg::CordicGain;
            y_q     <= '0;
            z_q     <= $signed({ang[31] ^ flip, ang[31] ^ flip, ang[30:0]});
            flip_q  <= flip;
            step_q  <= '0;
            state_q <= C_RUN;
          end
        end
        C_RUN: begin
          if (!z_q[ftpd_pkg::AngW-1]) begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - atan_s;
          end else begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + atan_s;
          end
          step_q <= step_q + 1'b1;
          if (step_q == ftpd_pkg::StepW'(ftpd_pkg::CordicLast)) begin
            state_q <= C_DONE;
          end
        end
        C_DONE:  state_q <= C_IDLE;
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign done_o = (state_q == C_DONE);
  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;

endmodule

>>> rtl/ftpd_mul.sv
// ----------------------------------------------------------------------------
// ftpd_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ftpd_mul (
  input  logic                               clk_i,
  input  logic signed [ftpd_pkg::MulW-1:0]   a_i,
  input  logic signed [ftpd_pkg::MulW-1:0]   b_i,
  output logic signed [ftpd_pkg::ProdW-1:0]  p_o
);

  logic signed [ftpd_pkg::ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

>>> rtl/frame_transform_point_decimator.sv
// ----------------------------------------------------------------------------
// frame_transform_point_decimator
// Rotates a vehicle-frame point by yaw, adds the vehicle position, flags the
// point as recorded if none is held or it is past the threshold from the last.
// ----------------------------------------------------------------------------
// A beat runs through the CORDIC iteration and then seven passes through the
// shared multiplier before its result is registered; no new beat is taken
// until the result has moved into the output register.
// A finished result waits in the output register while the next beat enters.
// Reset: threshold 3277, last point cleared, no point held.
module frame_transform_point_decimator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [ftpd_pkg::PosW-1:0]  vehicle_x_i,
  input  logic signed [ftpd_pkg::PosW-1:0]  vehicle_y_i,
  input  logic signed [ftpd_pkg::HdgW-1:0]  vehicle_heading_i,
  input  logic signed [ftpd_pkg::PosW-1:0]  local_x_i,
  input  logic signed [ftpd_pkg::PosW-1:0]  local_y_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [ftpd_pkg::PosW-1:0]  world_x_o,
  output logic signed [ftpd_pkg::PosW-1:0]  world_y_o,
  output logic                              recorded_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_CORDIC, S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_OUT
  } state_e;

  state_e                               state_q;
  logic [ftpd_pkg::ThrW-1:0]            thr_q;
  logic [ftpd_pkg::PosW-1:0]            vx_q, vy_q, lx_q, ly_q;
  logic [ftpd_pkg::PosW-1:0]            wx_q, wy_q, last_x_q, last_y_q;
  logic                                 have_point_q;
  logic signed [ftpd_pkg::AccW-1:0]     acc_q;
  logic [ftpd_pkg::SqW-1:0]             t2_q;
  logic                                 out_valid_q, rec_q;
  logic [ftpd_pkg::PosW-1:0]            out_x_q, out_y_q;

  logic                                 in_acc, out_free, rec;
  logic                                 cor_done;
  logic signed [ftpd_pkg::CorW-1:0]     cor_cos, cor_sin;
  logic signed [ftpd_pkg::MulW-1:0]     mul_a, mul_b;
  logic signed [ftpd_pkg::ProdW-1:0]    prod;
  logic signed [ftpd_pkg::AccW-1:0]     acc_shr;
  logic [33:0]                          pos_sum_x, pos_sum_y;
  logic [33:0]                          dx, dy;

  function automatic logic [31:0] sat34(input logic [33:0] v);
    logic [31:0] r;
    if (v[33:31] != {3{v[31]}}) begin
      r = v[33] ? 32'h80000000 : 32'h7FFFFFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign prdata = {1'b0, thr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ftpd_pkg::ThrReset;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      thr_q <= pwdata[ftpd_pkg::ThrW-1:0];
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  ftpd_cordic u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_acc),
    .heading_i (vehicle_heading_i),
    .done_o    (cor_done),
    .cos_o     (cor_cos),
    .sin_o     (cor_sin)
  );

  assign dx = {{2{last_x_q[31]}}, last_x_q} - {{2{wx_q[31]}}, wx_q};
  assign dy = {{2{last_y_q[31]}}, last_y_q} - {{2{wy_q[31]}}, wy_q};

  always_comb begin
    case (state_q)
      S_P0: begin
        mul_a = $signed({{2{lx_q[31]}}, lx_q});
        mul_b = cor_cos;
      end
      S_P1: begin
        mul_a = $signed({{2{ly_q[31]}}, ly_q});
        mul_b = cor_sin;
      end
      S_P2: begin
        mul_a = $signed({{2{lx_q[31]}}, lx_q});
        mul_b = cor_sin;
      end
      S_P3: begin
        mul_a = $signed({{2{ly_q[31]}}, ly_q});
        mul_b = cor_cos;
      end
      S_P4: begin
        mul_a = $signed({3'b000, thr_q});
        mul_b = $signed({3'b000, thr_q});
      end
      S_P5: begin
        mul_a = $signed(dx);
        mul_b = $signed(dx);
      end
      S_P6: begin
        mul_a = $signed(dy);
        mul_b = $signed(dy);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ftpd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign acc_shr   = acc_q >>> ftpd_pkg::FracShift;
  assign pos_sum_x = {{2{vx_q[31]}}, vx_q} + acc_shr[33:0];
  assign pos_sum_y = {{2{vy_q[31]}}, vy_q} + acc_shr[33:0];
  assign rec       = !have_point_q || ($unsigned(acc_q) > {4'b0000, t2_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      have_point_q <= 1'b0;
      last_x_q     <= '0;
      last_y_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            vx_q    <= vehicle_x_i;
            vy_q    <= vehicle_y_i;
            lx_q    <= local_x_i;
            ly_q    <= local_y_i;
            state_q <= S_CORDIC;
          end
        end
        S_CORDIC: begin
          if (cor_done) begin
            state_q <= S_P0;
          end
        end
        S_P0: state_q <= S_P1;
        S_P1: begin
          acc_q   <= prod + ftpd_pkg::RoundHalf;
          state_q <= S_P2;
        end
        S_P2: begin
          acc_q   <= acc_q - prod;
          state_q <= S_P3;
        end
        S_P3: begin
          wx_q    <= sat34(pos_sum_x);
          acc_q   <= prod + ftpd_pkg::RoundHalf;
          state_q <= S_P4;
        end
        S_P4: begin
          acc_q   <= acc_q + prod;
          state_q <= S_P5;
        end
        S_P5: begin
          wy_q    <= sat34(pos_sum_y);
          t2_q    <= prod[ftpd_pkg::SqW-1:0];
          state_q <= S_P6;
        end
        S_P6: begin
          acc_q   <= prod;
          state_q <= S_P7;
        end
        S_P7: begin
          acc_q   <= acc_q + prod;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_x_q     <= wx_q;
            out_y_q     <= wy_q;
            rec_q       <= rec;
            if (rec) begin
              last_x_q     <= wx_q;
              last_y_q     <= wy_q;
              have_point_q <= 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign world_x_o   = out_x_q;
  assign world_y_o   = out_y_q;
  assign recorded_o  = rec_q;

`ifndef SYNTHESIS
  a_cordic_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_done |-> state_q == S_CORDIC)
    else $error("cordic finished outside its wait state");

  a_have_point_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_point_q |=> have_point_q)
    else $error("held point flag dropped");

  a_recorded_matches_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && recorded_o |-> world_x_o == last_x_q && world_y_o == last_y_q)
    else $error("recorded beat differs from stored point");

  a_first_point_recorded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && !$past(have_point_q) |-> recorded_o)
    else $error("first point not recorded");
`endif

endmodule
